>>> design/sgb_pkg.sv
`default_nettype none
package sgb_pkg;

    localparam int MAX_WIDTH = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int MAX_RADIUS = 7;
    localparam int WEIGHT_FRAC_BITS = 15;
    localparam int WEIGHT_W = 16;
    localparam int TAPS = 2 * MAX_RADIUS + 1;
    localparam int CHAN_W = 8;
    localparam int ACC_W = CHAN_W + WEIGHT_W + $clog2(TAPS);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W = ADDR_W + 1;
    localparam int DIM_W = 9;
    localparam int POS_W = 8;
    localparam int WORD_W = 4 * CHAN_W;
    localparam int DIV_STEPS = 8;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_FETCH = 1'b1;

    typedef enum logic [2:0] {
        CFG_FRAME_WIDTH,
        CFG_FRAME_HEIGHT,
        CFG_BLUR_RADIUS,
        CFG_BLUR_ALPHA,
        CFG_TAPS_NEAR,
        CFG_TAPS_FAR
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HPASS,
        ST_DIV,
        ST_VPASS,
        ST_VWAIT,
        ST_VCAPT,
        ST_VDONE
    } state_t;

    // channel 0 is red, channel 3 is alpha
    typedef logic [3:0][CHAN_W-1:0] pixel_t;
    typedef logic [3:0][ACC_W-1:0] acc_t;
    typedef logic [WEIGHT_W-1:0] weight_t;
    typedef logic [TAPS-1:0][WEIGHT_W-1:0] weights_t;

    typedef struct packed {
        logic              cmd;
        logic [CHAN_W-1:0] red_in;
        logic [CHAN_W-1:0] green_in;
        logic [CHAN_W-1:0] blue_in;
        logic [CHAN_W-1:0] alpha_in;
    } in_item_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red_out;
        logic [CHAN_W-1:0] green_out;
        logic [CHAN_W-1:0] blue_out;
        logic [CHAN_W-1:0] alpha_out;
        logic              frame_last;
    } out_item_t;

    // drop the fraction bits and saturate to 8 bits
    function automatic logic [CHAN_W-1:0] finish_chan(input logic [ACC_W-1:0] sum);
        logic [ACC_W-WEIGHT_FRAC_BITS-1:0] v;
        v = sum[ACC_W-1:WEIGHT_FRAC_BITS];
        if (v > (ACC_W-WEIGHT_FRAC_BITS)'(255))
            return {CHAN_W{1'b1}};
        else
            return v[CHAN_W-1:0];
    endfunction

    function automatic pixel_t finish_pixel(input acc_t sum);
        pixel_t p;
        for (int c = 0; c < 4; c++)
            p[c] = finish_chan(sum[c]);
        return p;
    endfunction

endpackage
`default_nettype wire

>>> design/sgb_ram.sv
`default_nettype none
module sgb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

>>> design/sgb_cell.sv
`default_nettype none
module sgb_cell (
    input  wire logic            clk,
    input  wire sgb_pkg::weight_t weight,
    input  wire sgb_pkg::pixel_t  sample,
    input  wire sgb_pkg::acc_t    acc_right,
    input  wire sgb_pkg::pixel_t  sample_left,
    output sgb_pkg::acc_t         acc,
    output sgb_pkg::pixel_t       held
);

    sgb_pkg::acc_t acc_reg;
    sgb_pkg::acc_t acc_next;
    sgb_pkg::pixel_t held_reg;

    // transposed form: add own product to the partial sum from the right
    always_comb
    begin
        for (int c = 0; c < 4; c++)
            acc_next[c] = acc_right[c]
                        + sgb_pkg::ACC_W'(sample[c]) * sgb_pkg::ACC_W'(weight);
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        held_reg <= sample_left;
    end

    assign acc  = acc_reg;
    assign held = held_reg;

endmodule
`default_nettype wire

>>> design/sgb_cell_chain.sv
`default_nettype none
module sgb_cell_chain (
    input  wire logic             clk,
    input  wire sgb_pkg::weights_t weights,
    input  wire sgb_pkg::pixel_t   sample,
    output sgb_pkg::acc_t          sum,
    output sgb_pkg::pixel_t        center
);

    sgb_pkg::acc_t   acc_w  [sgb_pkg::TAPS+1];
    sgb_pkg::pixel_t held_w [sgb_pkg::TAPS+1];

    assign acc_w[sgb_pkg::TAPS] = '0;
    assign held_w[0] = sample;

    for (genvar i = 0; i < sgb_pkg::TAPS; i++)
    begin : g_cell
        sgb_cell u_cell (
            .clk         (clk),
            .weight      (weights[i]),
            .sample      (sample),
            .acc_right   (acc_w[i+1]),
            .sample_left (held_w[i]),
            .acc         (acc_w[i]),
            .held        (held_w[i+1])
        );
    end

    // cell 0 holds the full sum, and center is the sample on its middle tap
    assign sum    = acc_w[0];
    assign center = held_w[sgb_pkg::MAX_RADIUS+1];

endmodule
`default_nettype wire

>>> design/separable_gaussian_blur_unit.sv
`default_nettype none
// load: written straight into the frame memory; loads are taken whenever no fetch is running
// fetch: 8 quotient steps for the pixel position, 15 column reads through the cell
// chain, then the VWAIT, VCAPT and VDONE states drain and hand over; the first fetch of a
// frame first runs the row pass, height rows of width + 14 padded pixels, one frame read per cycle
// reset clears the counts, the sequencer and the output valid flag; memories are not cleared
module separable_gaussian_blur_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    output logic                    cmd_stall,
    input  wire sgb_pkg::in_item_t  cmd_item,
    output logic                    res_valid,
    input  wire logic               res_stall,
    output sgb_pkg::out_item_t      res_item,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [63:0]        cfg_data
);

    localparam int DW = sgb_pkg::DIM_W;
    localparam int PW = sgb_pkg::POS_W;
    localparam int AW = sgb_pkg::ADDR_W;
    localparam int CW = sgb_pkg::CNT_W;

    // configuration
    logic [DW-1:0] frame_width_reg, frame_height_reg;
    logic [2:0]    blur_radius_reg;
    logic          blur_alpha_reg;
    logic [63:0]   taps_near_reg, taps_far_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= DW'(256);
            frame_height_reg <= DW'(256);
            blur_radius_reg  <= 3'd2;
            blur_alpha_reg   <= 1'b1;
            taps_near_reg    <= 64'd32768;
            taps_far_reg     <= 64'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                sgb_pkg::CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[DW-1:0];
                sgb_pkg::CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data[DW-1:0];
                sgb_pkg::CFG_BLUR_RADIUS:  blur_radius_reg  <= cfg_data[2:0];
                sgb_pkg::CFG_BLUR_ALPHA:   blur_alpha_reg   <= cfg_data[0];
                sgb_pkg::CFG_TAPS_NEAR:    taps_near_reg    <= cfg_data;
                sgb_pkg::CFG_TAPS_FAR:     taps_far_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    logic [DW-1:0] eff_w, eff_h;
    logic [2:0]    eff_r;
    logic [CW-1:0] total;
    logic [2*DW-1:0] total_full;
    sgb_pkg::weights_t weights;

    always_comb
    begin
        int off;
        if (frame_width_reg == '0)
            eff_w = DW'(1);
        else if (frame_width_reg > DW'(sgb_pkg::MAX_WIDTH))
            eff_w = DW'(sgb_pkg::MAX_WIDTH);
        else
            eff_w = frame_width_reg;
        if (frame_height_reg == '0)
            eff_h = DW'(1);
        else if (frame_height_reg > DW'(sgb_pkg::MAX_HEIGHT))
            eff_h = DW'(sgb_pkg::MAX_HEIGHT);
        else
            eff_h = frame_height_reg;
        eff_r = (blur_radius_reg > 3'(sgb_pkg::MAX_RADIUS)) ?
                3'(sgb_pkg::MAX_RADIUS) : blur_radius_reg;
        total_full = eff_w * eff_h;
        total = total_full[CW-1:0];
        for (int i = 0; i < sgb_pkg::TAPS; i++)
        begin
            off = (i < sgb_pkg::MAX_RADIUS) ? sgb_pkg::MAX_RADIUS - i
                                            : i - sgb_pkg::MAX_RADIUS;
            if (off > int'(eff_r))
                weights[i] = '0;
            else if (off < 4)
                weights[i] = taps_near_reg[off*16 +: 16];
            else
                weights[i] = taps_far_reg[(off-4)*16 +: 16];
        end
    end

    // sequencer state
    sgb_pkg::state_t state_reg, state_next;
    logic [CW-1:0] load_count_reg, load_count_next;
    logic [CW-1:0] emit_count_reg, emit_count_next;
    logic [PW-1:0] hy_reg;
    logic [DW-1:0] hm_reg;
    logic [AW-1:0] hbase_reg;
    logic [CW-1:0] rem_reg;
    logic [PW-1:0] quo_reg;
    logic [2:0]    bit_reg;
    logic [3:0]    vj_reg;
    logic          sel_h_reg;
    logic          tag1_valid_reg, tag2_valid_reg;
    logic [AW-1:0] tag1_addr_reg, tag2_addr_reg;
    logic [7:0]    alpha_keep_reg;
    sgb_pkg::pixel_t hold_reg;
    logic          res_valid_reg;
    sgb_pkg::out_item_t res_item_reg;

    logic cmd_fire, is_load, wrap, complete, out_free, row_end, last_pixel;
    logic [CW-1:0] lc, ec, emit_inc;
    logic [DW-1:0] hm_sub, vt, vt_sub;
    logic [PW-1:0] hx, py;
    logic [CW-1:0] div_cmp;
    logic [DW+PW-1:0] vprod;

    logic          frame_we;
    logic [AW-1:0] frame_waddr, frame_raddr, row_raddr;
    logic [sgb_pkg::WORD_W-1:0] frame_wdata, frame_rdata, row_wdata, row_rdata;
    sgb_pkg::pixel_t sample, center, row_pix, v_pix;
    sgb_pkg::acc_t   sum;

    assign cmd_stall = (state_reg != sgb_pkg::ST_IDLE);
    assign cmd_fire  = cmd_valid && !cmd_stall;
    assign is_load   = (cmd_item.cmd == sgb_pkg::CMD_LOAD);

    // a finished frame wraps both counts before the transaction is looked at
    assign wrap     = (load_count_reg >= total) && (emit_count_reg >= total);
    assign lc       = wrap ? '0 : load_count_reg;
    assign ec       = wrap ? '0 : emit_count_reg;
    assign complete = (lc >= total);
    assign out_free = !res_valid_reg || !res_stall;
    assign emit_inc = emit_count_reg + CW'(1);
    assign last_pixel = (emit_inc == total);

    // row pass: stream each row padded by MAX_RADIUS clamped pixels on both sides
    assign hm_sub  = hm_reg - DW'(sgb_pkg::MAX_RADIUS);
    assign hx      = (hm_reg < DW'(sgb_pkg::MAX_RADIUS)) ? '0 :
                     (hm_sub >= eff_w) ? PW'(eff_w - DW'(1)) : hm_sub[PW-1:0];
    assign row_end = (hm_reg == DW'(eff_w + DW'(2*sgb_pkg::MAX_RADIUS - 1)));

    assign div_cmp = CW'(eff_w) << bit_reg;

    // column pass: row index clamped to the frame
    assign vt     = {1'b0, quo_reg} + DW'(vj_reg);
    assign vt_sub = vt - DW'(sgb_pkg::MAX_RADIUS);
    assign py     = (vt < DW'(sgb_pkg::MAX_RADIUS)) ? '0 :
                    (vt_sub >= eff_h) ? PW'(eff_h - DW'(1)) : vt_sub[PW-1:0];
    assign vprod  = py * eff_w;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sgb_pkg::ST_IDLE:
                if (cmd_fire && !is_load && complete)
                    state_next = (ec == '0) ? sgb_pkg::ST_HPASS : sgb_pkg::ST_DIV;
            sgb_pkg::ST_HPASS:
                if (row_end && (hy_reg == PW'(eff_h - DW'(1))))
                    state_next = sgb_pkg::ST_DIV;
            sgb_pkg::ST_DIV:
                if (bit_reg == '0)
                    state_next = sgb_pkg::ST_VPASS;
            sgb_pkg::ST_VPASS:
                if (vj_reg == 4'(sgb_pkg::TAPS - 1))
                    state_next = sgb_pkg::ST_VWAIT;
            sgb_pkg::ST_VWAIT:
                state_next = sgb_pkg::ST_VCAPT;
            sgb_pkg::ST_VCAPT:
                state_next = sgb_pkg::ST_VDONE;
            sgb_pkg::ST_VDONE:
                if (out_free)
                    state_next = sgb_pkg::ST_IDLE;
            default:
                state_next = sgb_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        load_count_next = load_count_reg;
        emit_count_next = emit_count_reg;
        frame_we    = 1'b0;
        frame_waddr = lc[AW-1:0];
        frame_wdata = {cmd_item.alpha_in, cmd_item.blue_in,
                       cmd_item.green_in, cmd_item.red_in};
        frame_raddr = hbase_reg + AW'(hx);
        row_raddr   = AW'(vprod) + AW'(rem_reg[PW-1:0]);
        case (state_reg)
            sgb_pkg::ST_IDLE:
                if (cmd_fire)
                begin
                    emit_count_next = ec;
                    load_count_next = lc;
                    if (is_load && !complete)
                    begin
                        frame_we        = 1'b1;
                        load_count_next = lc + CW'(1);
                    end
                end
            sgb_pkg::ST_VPASS:
                frame_raddr = emit_count_reg[AW-1:0];
            sgb_pkg::ST_VDONE:
                if (out_free)
                begin
                    if (last_pixel)
                    begin
                        load_count_next = '0;
                        emit_count_next = '0;
                    end
                    else
                        emit_count_next = emit_inc;
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sgb_pkg::ST_IDLE;
            load_count_reg <= '0;
            emit_count_reg <= '0;
            hy_reg         <= '0;
            hm_reg         <= '0;
            hbase_reg      <= '0;
            bit_reg        <= 3'(sgb_pkg::DIV_STEPS - 1);
            vj_reg         <= '0;
            sel_h_reg      <= 1'b0;
            tag1_valid_reg <= 1'b0;
            tag2_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            load_count_reg <= load_count_next;
            emit_count_reg <= emit_count_next;

            if (state_reg == sgb_pkg::ST_HPASS)
            begin
                if (row_end)
                begin
                    hm_reg    <= '0;
                    hy_reg    <= hy_reg + PW'(1);
                    hbase_reg <= hbase_reg + AW'(eff_w);
                end
                else
                    hm_reg <= hm_reg + DW'(1);
            end
            else
            begin
                hm_reg    <= '0;
                hy_reg    <= '0;
                hbase_reg <= '0;
            end

            if (state_reg == sgb_pkg::ST_DIV)
                bit_reg <= bit_reg - 3'd1;
            else
                bit_reg <= 3'(sgb_pkg::DIV_STEPS - 1);

            if (state_reg == sgb_pkg::ST_VPASS)
                vj_reg <= vj_reg + 4'd1;
            else
                vj_reg <= '0;

            sel_h_reg      <= (state_reg == sgb_pkg::ST_HPASS);
            tag1_valid_reg <= (state_reg == sgb_pkg::ST_HPASS) &&
                              (hm_reg >= DW'(2*sgb_pkg::MAX_RADIUS));
            tag2_valid_reg <= tag1_valid_reg;

            if (state_reg == sgb_pkg::ST_VDONE && out_free)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;
        end
    end

    // datapath registers without reset
    always_ff @(posedge clk)
    begin
        if (state_reg == sgb_pkg::ST_DIV)
        begin
            if (rem_reg >= div_cmp)
            begin
                rem_reg          <= rem_reg - div_cmp;
                quo_reg[bit_reg] <= 1'b1;
            end
        end
        else if (state_reg == sgb_pkg::ST_IDLE || state_reg == sgb_pkg::ST_HPASS)
        begin
            rem_reg <= emit_count_next;
            quo_reg <= '0;
        end

        tag1_addr_reg <= hbase_reg + AW'(hm_reg - DW'(2*sgb_pkg::MAX_RADIUS));
        tag2_addr_reg <= tag1_addr_reg;

        if (state_reg == sgb_pkg::ST_VPASS && vj_reg == 4'd1)
            alpha_keep_reg <= frame_rdata[sgb_pkg::WORD_W-1 -: 8];

        if (state_reg == sgb_pkg::ST_VCAPT)
            hold_reg <= v_pix;

        if (state_reg == sgb_pkg::ST_VDONE && out_free)
        begin
            res_item_reg.red_out    <= hold_reg[0];
            res_item_reg.green_out  <= hold_reg[1];
            res_item_reg.blue_out   <= hold_reg[2];
            res_item_reg.alpha_out  <= hold_reg[3];
            res_item_reg.frame_last <= last_pixel;
        end
    end

    assign sample = sel_h_reg ? sgb_pkg::pixel_t'(frame_rdata)
                              : sgb_pkg::pixel_t'(row_rdata);

    always_comb
    begin
        row_pix = sgb_pkg::finish_pixel(sum);
        if (!blur_alpha_reg)
            row_pix[3] = center[3];
        v_pix = sgb_pkg::finish_pixel(sum);
        if (!blur_alpha_reg)
            v_pix[3] = alpha_keep_reg;
    end

    assign row_wdata = row_pix;

    sgb_ram #(
        .WIDTH (sgb_pkg::WORD_W),
        .DEPTH (sgb_pkg::DEPTH)
    ) u_frame_ram (
        .clk     (clk),
        .wr_en   (frame_we),
        .wr_addr (frame_waddr),
        .wr_data (frame_wdata),
        .rd_addr (frame_raddr),
        .rd_data (frame_rdata)
    );

    sgb_ram #(
        .WIDTH (sgb_pkg::WORD_W),
        .DEPTH (sgb_pkg::DEPTH)
    ) u_row_ram (
        .clk     (clk),
        .wr_en   (tag2_valid_reg),
        .wr_addr (tag2_addr_reg),
        .wr_data (row_wdata),
        .rd_addr (row_raddr),
        .rd_data (row_rdata)
    );

    sgb_cell_chain u_chain (
        .clk     (clk),
        .weights (weights),
        .sample  (sample),
        .sum     (sum),
        .center  (center)
    );

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

endmodule
`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
module tb;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 64;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cmd_valid;
    logic                cmd_stall;
    sgb_pkg::in_item_t   cmd_item;
    logic                res_valid;
    logic                res_stall;
    sgb_pkg::out_item_t  res_item;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [2:0]          cfg_index;
    logic [63:0]         cfg_data;

    separable_gaussian_blur_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // blur predictor state
    logic [8:0]        width_reg;
    logic [8:0]        height_reg;
    logic [2:0]        radius_reg;
    logic              alpha_blur_reg;
    logic [63:0]       near_taps;
    logic [63:0]       far_taps;
    logic [3:0][7:0]   frame_mem [0:sgb_pkg::DEPTH-1];
    logic [3:0][7:0]   hpass_mem [0:sgb_pkg::DEPTH-1];
    int unsigned       pixels_loaded;
    int unsigned       pixels_blurred;

    sgb_pkg::out_item_t blurred_pixels_due[$];
    int          error_count;
    int          items_sent;
    int          sender_idle_pct;
    int          receiver_stall_pct;
    int          hold_request;
    int          hold_left;
    int          quiet_cycles;

    task automatic report(input string what, input int got, input int want);
        $display("mismatch on %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic int unsigned eff_w();
        if (width_reg == 0) return 1;
        if (width_reg > sgb_pkg::MAX_WIDTH) return sgb_pkg::MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic int unsigned eff_h();
        if (height_reg == 0) return 1;
        if (height_reg > sgb_pkg::MAX_HEIGHT) return sgb_pkg::MAX_HEIGHT;
        return height_reg;
    endfunction

    function automatic longint unsigned tap(input int k);
        if (k < 4) return near_taps[k*16 +: 16];
        return far_taps[(k-4)*16 +: 16];
    endfunction

    function automatic logic [7:0] saturate(input longint unsigned sum);
        longint unsigned v;
        v = sum >> sgb_pkg::WEIGHT_FRAC_BITS;
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function automatic int clampv(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic void row_blur();
        int w;
        int h;
        int r;
        int nch;
        longint unsigned sum;
        logic [3:0][7:0] o;
        w = eff_w();
        h = eff_h();
        r = radius_reg;
        nch = alpha_blur_reg ? 4 : 3;
        for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++)
            begin
                o = '0;
                if (nch == 3)
                    o[3] = frame_mem[y*w + x][3];
                for (int c = 0; c < nch; c++)
                begin
                    sum = 0;
                    for (int k = -r; k <= r; k++)
                        sum += frame_mem[y*w + clampv(x + k, 0, w - 1)][c]
                               * tap(k < 0 ? -k : k);
                    o[c] = saturate(sum);
                end
                hpass_mem[y*w + x] = o;
            end
    endfunction

    // one accepted item through the predictor; queues the expected pixel if any
    function automatic void predict_blur(input sgb_pkg::in_item_t it);
        int unsigned w;
        int unsigned total;
        int y;
        int x;
        int r;
        int nch;
        longint unsigned sum;
        sgb_pkg::out_item_t o;
        w = eff_w();
        total = w * eff_h();
        if (pixels_loaded >= total && pixels_blurred >= total)
        begin
            pixels_loaded = 0;
            pixels_blurred = 0;
        end
        if (it.cmd == sgb_pkg::CMD_LOAD)
        begin
            if (pixels_loaded < total)
            begin
                frame_mem[pixels_loaded] = {it.alpha_in, it.blue_in, it.green_in, it.red_in};
                pixels_loaded++;
            end
            return;
        end
        if (pixels_loaded < total)
            return;
        if (pixels_blurred == 0)
            row_blur();
        r = radius_reg;
        y = pixels_blurred / w;
        x = pixels_blurred % w;
        nch = alpha_blur_reg ? 4 : 3;
        o = '0;
        for (int c = 0; c < nch; c++)
        begin
            sum = 0;
            for (int k = -r; k <= r; k++)
                sum += hpass_mem[clampv(y + k, 0, eff_h() - 1) * w + x][c]
                       * tap(k < 0 ? -k : k);
            case (c)
                0: o.red_out = saturate(sum);
                1: o.green_out = saturate(sum);
                2: o.blue_out = saturate(sum);
                default: o.alpha_out = saturate(sum);
            endcase
        end
        if (nch == 3)
            o.alpha_out = frame_mem[pixels_blurred][3];
        pixels_blurred++;
        o.frame_last = (pixels_blurred == total);
        if (pixels_blurred == total)
        begin
            pixels_loaded = 0;
            pixels_blurred = 0;
        end
        blurred_pixels_due.push_back(o);
    endfunction

    task automatic send_item(input logic cmd, input logic [31:0] px);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(0, 99) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_item <= '{cmd, px[7:0], px[15:8], px[23:16], px[31:24]};
        do @(posedge clk); while (cmd_stall);
        predict_blur('{cmd, px[7:0], px[15:8], px[23:16], px[31:24]});
        items_sent++;
    endtask

    task automatic wait_drained();
        cmd_valid <= 1'b0;
        while (blurred_pixels_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input sgb_pkg::cfg_index_t idx, input logic [63:0] d);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            sgb_pkg::CFG_FRAME_WIDTH: width_reg = d[8:0];
            sgb_pkg::CFG_FRAME_HEIGHT: height_reg = d[8:0];
            sgb_pkg::CFG_BLUR_RADIUS: radius_reg = d[2:0];
            sgb_pkg::CFG_BLUR_ALPHA: alpha_blur_reg = d[0];
            sgb_pkg::CFG_TAPS_NEAR: near_taps = d;
            default: far_taps = d;
        endcase
    endtask

    function automatic logic [63:0] rand_taps();
        logic [63:0] t;
        for (int i = 0; i < 4; i++)
            t[i*16 +: 16] = ($urandom_range(0, 1)) ? 16'($urandom) : 16'($urandom_range(0, 6000));
        return t;
    endfunction

    // loads a whole frame then fetches it, with stray fetches and loads mixed in
    task automatic blur_frame(input int noise_pct);
        int total;
        total = eff_w() * eff_h();
        for (int i = 0; i < total; i++)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                send_item(sgb_pkg::CMD_FETCH, $urandom);
            send_item(sgb_pkg::CMD_LOAD, $urandom);
        end
        for (int i = 0; i < total; i++)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                send_item(sgb_pkg::CMD_LOAD, $urandom);
            send_item(sgb_pkg::CMD_FETCH, $urandom);
        end
    endtask

    task automatic test_directed();
        logic [31:0] corner [4];
        corner = '{32'h00000000, 32'hFFFFFFFF, 32'hAA55AA55, 32'h55AA55AA};
        // fetch with no frame loaded gives nothing
        send_item(sgb_pkg::CMD_FETCH, 32'hFFFFFFFF);
        cfg_write(sgb_pkg::CFG_FRAME_WIDTH, 64'd3);
        cfg_write(sgb_pkg::CFG_FRAME_HEIGHT, 64'd2);
        cfg_write(sgb_pkg::CFG_BLUR_RADIUS, 64'd7);
        cfg_write(sgb_pkg::CFG_BLUR_ALPHA, 64'd0);
        cfg_write(sgb_pkg::CFG_TAPS_NEAR, 64'hFFFF_FFFF_FFFF_FFFF);
        cfg_write(sgb_pkg::CFG_TAPS_FAR, 64'hFFFF_FFFF_FFFF_FFFF);
        for (int i = 0; i < 6; i++)
            send_item(sgb_pkg::CMD_LOAD, corner[i % 4]);
        // frame full: this load is dropped
        send_item(sgb_pkg::CMD_LOAD, 32'h12345678);
        for (int i = 0; i < 6; i++)
            send_item(sgb_pkg::CMD_FETCH, 32'h0);
        cfg_write(sgb_pkg::CFG_FRAME_WIDTH, 64'd1);
        cfg_write(sgb_pkg::CFG_FRAME_HEIGHT, 64'd1);
        cfg_write(sgb_pkg::CFG_BLUR_RADIUS, 64'd0);
        cfg_write(sgb_pkg::CFG_BLUR_ALPHA, 64'd1);
        cfg_write(sgb_pkg::CFG_TAPS_NEAR, 64'h8000);
        cfg_write(sgb_pkg::CFG_TAPS_FAR, 64'h0);
        send_item(sgb_pkg::CMD_LOAD, 32'hFF00FF80);
        send_item(sgb_pkg::CMD_FETCH, 32'h0);
        wait_drained();
    endtask

    task automatic test_size_extremes();
        cfg_write(sgb_pkg::CFG_BLUR_RADIUS, 64'd7);
        cfg_write(sgb_pkg::CFG_TAPS_NEAR, 64'h0800_1000_1800_2000);
        cfg_write(sgb_pkg::CFG_TAPS_FAR, 64'h0100_0200_0300_0400);
        // width above the maximum and height of zero both clamp
        cfg_write(sgb_pkg::CFG_FRAME_WIDTH, 64'd300);
        cfg_write(sgb_pkg::CFG_FRAME_HEIGHT, 64'd0);
        blur_frame(0);
        cfg_write(sgb_pkg::CFG_FRAME_WIDTH, 64'd0);
        cfg_write(sgb_pkg::CFG_FRAME_HEIGHT, 64'd40);
        cfg_write(sgb_pkg::CFG_BLUR_ALPHA, 64'd0);
        blur_frame(0);
        wait_drained();
    endtask

    task automatic test_backpressure();
        cfg_write(sgb_pkg::CFG_FRAME_WIDTH, 64'd4);
        cfg_write(sgb_pkg::CFG_FRAME_HEIGHT, 64'd4);
        cfg_write(sgb_pkg::CFG_BLUR_RADIUS, 64'd1);
        for (int i = 0; i < 16; i++)
            send_item(sgb_pkg::CMD_LOAD, $urandom);
        hold_request = 400;
        for (int i = 0; i < 16; i++)
            send_item(sgb_pkg::CMD_FETCH, $urandom);
        wait_drained();
    endtask

    task automatic test_random_frames(input int stop_at, input int tx_pct, input int rx_pct);
        sender_idle_pct = tx_pct;
        receiver_stall_pct = rx_pct;
        while (items_sent < stop_at)
        begin
            cfg_write(sgb_pkg::CFG_FRAME_WIDTH,
                      ($urandom_range(0, 19) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 6));
            cfg_write(sgb_pkg::CFG_FRAME_HEIGHT,
                      ($urandom_range(0, 19) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 6));
            cfg_write(sgb_pkg::CFG_BLUR_RADIUS, $urandom_range(0, 7));
            cfg_write(sgb_pkg::CFG_BLUR_ALPHA, $urandom_range(0, 1));
            cfg_write(sgb_pkg::CFG_TAPS_NEAR, rand_taps());
            cfg_write(sgb_pkg::CFG_TAPS_FAR, rand_taps());
            blur_frame(10);
            // sender pause until everything is back
            if ($urandom_range(0, 3) == 0)
                wait_drained();
        end
        wait_drained();
    endtask

    // result checker
    always @(posedge clk)
    begin
        sgb_pkg::out_item_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (blurred_pixels_due.size() == 0)
                report("unexpected result transaction", 1, 0);
            else
            begin
                want = blurred_pixels_due.pop_front();
                if (res_item.red_out !== want.red_out)
                    report("red_out", res_item.red_out, want.red_out);
                if (res_item.green_out !== want.green_out)
                    report("green_out", res_item.green_out, want.green_out);
                if (res_item.blue_out !== want.blue_out)
                    report("blue_out", res_item.blue_out, want.blue_out);
                if (res_item.alpha_out !== want.alpha_out)
                    report("alpha_out", res_item.alpha_out, want.alpha_out);
                if (res_item.frame_last !== want.frame_last)
                    report("frame_last", res_item.frame_last, want.frame_last);
            end
        end
    end

    // receiver stall, with an occasional long hold-off
    always @(posedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res_stall <= 1'b1;
        end
        else
            res_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready)
            || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd_item = '0;
        res_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        width_reg = 9'd256;
        height_reg = 9'd256;
        radius_reg = 3'd2;
        alpha_blur_reg = 1'b1;
        near_taps = 64'd32768;
        far_taps = 64'd0;
        pixels_loaded = 0;
        pixels_blurred = 0;
        error_count = 0;
        items_sent = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        hold_request = 0;
        hold_left = 0;
        quiet_cycles = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_size_extremes();
        test_backpressure();
        test_random_frames(items_sent + 128, 0, 0);
        test_random_frames(items_sent + 128, 70, 0);
        test_random_frames(items_sent + 128, 0, 70);
        test_random_frames(items_sent + 128, 17, 17);

        if (blurred_pixels_due.size() != 0)
            report("result transactions outstanding", blurred_pixels_due.size(), 0);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
